>>> rtl/core/reference_domain_test_and_clamp_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the reference domain test and clamp block.
// Each macro samples on clk and is switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef REFERENCE_DOMAIN_TEST_AND_CLAMP_MACROS_SVH
`define REFERENCE_DOMAIN_TEST_AND_CLAMP_MACROS_SVH

// A condition that must hold whenever the antecedent holds, in the same cycle.
`define RDTC_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must hold in the cycle after the antecedent.
`define RDTC_IMPLY_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rdtc_pkg.sv
// ----------------------------------------------------------------------------
// rdtc_pkg
// Shared types, constants and helpers of the reference domain clamp block.
// ----------------------------------------------------------------------------
package rdtc_pkg;

  localparam int CW      = 24;          // coordinate width, Q7.16
  localparam int FRAC    = 16;          // fraction bits
  localparam int EW      = CW + 3;      // signed width for sums and bounds
  localparam int SUM_W   = CW + 2;      // unsigned width of a coordinate sum
  localparam int QW      = FRAC + 1;    // quotient bits, value at most 1.0
  localparam int NLANE   = 3;           // coordinates per point
  localparam int TOL_W   = 16;
  localparam int IDX_W   = 2;

  localparam logic signed [EW-1:0] FIX_ONE = EW'(1) <<< FRAC;

  typedef enum logic [IDX_W-1:0] {
    REG_BOX_LOW  = 2'd0,
    REG_BOX_HIGH = 2'd1,
    REG_TOL      = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    SHP_SIMPLEX = 3'd0,
    SHP_BOX     = 3'd1,
    SHP_PRISM   = 3'd2,
    SHP_PYRAMID = 3'd3
  } shape_t;

  localparam logic OP_TEST  = 1'b0;
  localparam logic OP_CLAMP = 1'b1;

  typedef logic signed [CW-1:0] coord_t;

  // Side data that rides along the divider pipeline.
  typedef struct packed {
    logic             hit;     // inside flag of a test
    logic [NLANE-1:0] sel;     // lanes that take the quotient
    coord_t [NLANE-1:0] pre;   // value of each lane when no quotient is taken
  } side_t;

  function automatic coord_t box_clamp(coord_t x, coord_t lo, coord_t hi);
    coord_t t;
    t = (x < lo) ? lo : x;
    return (t > hi) ? hi : t;
  endfunction

endpackage

>>> rtl/core/reference_domain_test_and_clamp.sv
// ----------------------------------------------------------------------------
// reference_domain_test_and_clamp
// Inside test and projection of a local point into a finite-element
// reference domain (simplex, box, prism, pyramid).
// ----------------------------------------------------------------------------
// Each input item carries three Q7.16 coordinates in s_axis_tdata and the
// opcode, shape code and dimension in s_axis_tuser. Each item yields exactly
// one result item on the master side: the inside flag in m_axis_tuser and
// the three coordinates in m_axis_tdata, clamped on a clamp operation and
// copied unchanged on a test.
// The pipeline takes one item per cycle while the output is not stalled. Its
// stages are an input register, one stage that evaluates the test and the
// box and pyramid clamps, 17 stages of the quotient divider (one quotient
// bit each) and the output register. The divider sets the depth.
// Configuration registers are written through cfg_we, cfg_index and cfg_wdata,
// one per cycle, by the user only while no item is in flight (not enforced).
// Reset empties the pipeline and loads the box bounds with -1.0 and +1.0 and
// the tolerance with zero. When the receiver holds m_axis_tready low with a
// result waiting, the whole pipeline freezes and s_axis_tready drops in the
// same cycle, so no item is lost or repeated.
// ----------------------------------------------------------------------------
`include "reference_domain_test_and_clamp_macros.svh"

module reference_domain_test_and_clamp
  import rdtc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [NLANE*CW-1:0]    s_axis_tdata,  // coord_a, coord_b, coord_c
  input  logic [5:0]             s_axis_tuser,  // opcode, shape, dimension
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [NLANE*CW-1:0]    m_axis_tdata,  // out_a, out_b, out_c
  output logic                   m_axis_tuser,  // inside_res
  input  logic                   cfg_we,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [CW-1:0]          cfg_wdata
);

  // Configuration registers.
  coord_t            box_low;
  coord_t            box_high;
  logic [TOL_W-1:0]  tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_low   <= -CW'(FIX_ONE);
      box_high  <= CW'(FIX_ONE);
      tolerance <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BOX_LOW:  box_low   <= cfg_wdata;
        REG_BOX_HIGH: box_high  <= cfg_wdata;
        REG_TOL:      tolerance <= cfg_wdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together unless a result waits with m_axis_tready low.
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Stage 0: input register.
  logic                s0_valid;
  logic                s0_op;
  logic [2:0]          s0_shape;
  logic [1:0]          s0_dim;
  coord_t [NLANE-1:0]  s0_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_op    <= s_axis_tuser[0];
      s0_shape <= s_axis_tuser[3:1];
      s0_dim   <= s_axis_tuser[5:4];
      s0_c     <= s_axis_tdata;
    end
  end

  // Stage 1: tests, direct clamps and the divider operands.
  logic signed [EW-1:0] ea, eb, ec, lo, hi, tl, lim, lim_nn, ssum;
  logic                 use_a, use_b, use_c, ge_a, ge_b, ge_c;
  logic                 box_a, box_b, box_c, in_dom;
  logic [CW-2:0]        nna, nnb, nnc;
  coord_t               bca, bcb, bcc;
  logic [SUM_W-1:0]     dsum;
  logic [NLANE-1:0][SUM_W-1:0] dnum;
  side_t                side;

  always_comb begin
    ea    = EW'(s0_c[0]);
    eb    = EW'(s0_c[1]);
    ec    = EW'(s0_c[2]);
    lo    = EW'(box_low);
    hi    = EW'(box_high);
    tl    = EW'(tolerance);
    use_a = s0_dim >= 2'd1;
    use_b = s0_dim >= 2'd2;
    use_c = s0_dim >= 2'd3;
    ge_a  = ea >= -tl;
    ge_b  = eb >= -tl;
    ge_c  = ec >= -tl;
    box_a = (ea >= lo - tl) && (ea <= hi + tl);
    box_b = (eb >= lo - tl) && (eb <= hi + tl);
    box_c = (ec >= lo - tl) && (ec <= hi + tl);
    nna   = s0_c[0][CW-1] ? '0 : s0_c[0][CW-2:0];
    nnb   = s0_c[1][CW-1] ? '0 : s0_c[1][CW-2:0];
    nnc   = s0_c[2][CW-1] ? '0 : s0_c[2][CW-2:0];
    bca   = box_clamp(s0_c[0], box_low, box_high);
    bcb   = box_clamp(s0_c[1], box_low, box_high);
    bcc   = box_clamp(s0_c[2], box_low, box_high);
    ssum  = (use_a ? ea : '0) + (use_b ? eb : '0) + (use_c ? ec : '0);
    // Pyramid apex limit uses c after the box clamp.
    lim    = FIX_ONE - EW'(bcc);
    lim_nn = lim[EW-1] ? '0 : lim;

    in_dom = 1'b0;
    case (s0_shape)
      SHP_SIMPLEX: in_dom = (!use_a || ge_a) && (!use_b || ge_b) && (!use_c || ge_c)
                            && (ssum <= FIX_ONE + tl);
      SHP_BOX:     in_dom = (!use_a || box_a) && (!use_b || box_b) && (!use_c || box_c);
      SHP_PRISM:   in_dom = ge_a && ge_b && (ea + eb <= FIX_ONE + tl) && box_c;
      SHP_PYRAMID: in_dom = box_c && ge_a && ge_b && (ea <= FIX_ONE - ec + tl)
                            && (eb <= FIX_ONE - ec + tl);
      default:     in_dom = 1'b0;
    endcase

    dnum = '0;
    dsum = '0;
    side.hit = (s0_op == OP_TEST) && in_dom;
    side.sel = '0;
    side.pre = s0_c;
    if (s0_op == OP_CLAMP) begin
      case (s0_shape)
        SHP_SIMPLEX: begin
          dnum[0] = use_a ? SUM_W'(nna) : '0;
          dnum[1] = use_b ? SUM_W'(nnb) : '0;
          dnum[2] = use_c ? SUM_W'(nnc) : '0;
          dsum    = dnum[0] + dnum[1] + dnum[2];
          if (use_a) side.pre[0] = CW'(nna);
          if (use_b) side.pre[1] = CW'(nnb);
          if (use_c) side.pre[2] = CW'(nnc);
          if (dsum > SUM_W'(FIX_ONE)) side.sel = {use_c, use_b, use_a};
        end
        SHP_BOX: begin
          if (use_a) side.pre[0] = bca;
          if (use_b) side.pre[1] = bcb;
          if (use_c) side.pre[2] = bcc;
        end
        SHP_PRISM: begin
          dnum[0]     = SUM_W'(nna);
          dnum[1]     = SUM_W'(nnb);
          dsum        = dnum[0] + dnum[1];
          side.pre[0] = CW'(nna);
          side.pre[1] = CW'(nnb);
          side.pre[2] = bcc;
          if (dsum > SUM_W'(FIX_ONE)) side.sel = 3'b011;
        end
        SHP_PYRAMID: begin
          side.pre[0] = (EW'(nna) > lim_nn) ? CW'(lim_nn) : CW'(nna);
          side.pre[1] = (EW'(nnb) > lim_nn) ? CW'(lim_nn) : CW'(nnb);
          side.pre[2] = bcc;
        end
        default: ;
      endcase
    end
  end

  logic                         s1_valid;
  logic [NLANE-1:0][SUM_W-1:0]  s1_num;
  logic [SUM_W-1:0]             s1_sum;
  side_t                        s1_side;
  logic                         s1_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_num  <= dnum;
      s1_sum  <= dsum;
      s1_side <= side;
      s1_op   <= s0_op;
    end
  end

  // Divider stages.
  logic                       d_valid;
  logic [NLANE-1:0][QW-1:0]   d_q;
  side_t                      d_side;

  rdtc_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s1_valid),
    .in_num    (s1_num),
    .in_sum    (s1_sum),
    .in_side   (s1_side),
    .out_valid (d_valid),
    .out_q     (d_q),
    .out_side  (d_side)
  );

  // Output register: pick the quotient for the rescaled lanes. The quotient
  // never exceeds 1.0, so it always fits the coordinate format.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tuser <= d_side.hit;
      for (int l = 0; l < NLANE; l++) begin
        m_axis_tdata[l*CW +: CW] <= d_side.sel[l] ? CW'(d_q[l]) : d_side.pre[l];
      end
    end
  end

  // A clamp never reports inside.
  `RDTC_IMPLY(a_clamp_not_inside, s1_valid && (s1_op == OP_CLAMP), !s1_side.hit,
    "clamp item carries an inside flag")
  // Rescaling is chosen only when the sum exceeds one.
  `RDTC_IMPLY(a_div_sum, s1_valid && (s1_side.sel != '0), s1_sum > SUM_W'(FIX_ONE),
    "rescale selected with sum not above one")
  // The quotient of lane a, when rescaled, stays at or below one.
  `RDTC_IMPLY(a_quo_range, d_valid && d_side.sel[0], d_q[0] <= QW'(FIX_ONE),
    "quotient above one")
  // A waiting result stays until taken.
  `RDTC_IMPLY_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

>>> rtl/core/rdtc_div_pipe.sv
// ----------------------------------------------------------------------------
// rdtc_div_pipe
// Pipelined restoring divider: three lanes of num * 2^16 / sum, one quotient
// bit per stage. Every numerator is at most the sum, so the quotient fits
// in FRAC + 1 bits.
// ----------------------------------------------------------------------------
module rdtc_div_pipe
  import rdtc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [NLANE-1:0][SUM_W-1:0] in_num,
  input  logic [SUM_W-1:0]           in_sum,
  input  side_t                      in_side,
  output logic                       out_valid,
  output logic [NLANE-1:0][QW-1:0]   out_q,
  output side_t                      out_side
);

  logic [QW-1:0]                        valid;
  logic [QW-1:0][NLANE-1:0][SUM_W-1:0]  rem;
  logic [QW-1:0][NLANE-1:0][QW-1:0]     quo;
  logic [QW-1:0][SUM_W-1:0]             sum;
  side_t [QW-1:0]                       side;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[QW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // First stage decides the integer bit: whether num equals the sum.
      sum[0]  <= in_sum;
      side[0] <= in_side;
      for (int l = 0; l < NLANE; l++) begin
        if (in_num[l] >= in_sum) begin
          rem[0][l] <= in_num[l] - in_sum;
          quo[0][l] <= QW'(1);
        end else begin
          rem[0][l] <= in_num[l];
          quo[0][l] <= '0;
        end
      end
      // Each later stage adds one fraction bit.
      for (int k = 1; k < QW; k++) begin
        sum[k]  <= sum[k-1];
        side[k] <= side[k-1];
        for (int l = 0; l < NLANE; l++) begin
          if ({rem[k-1][l][SUM_W-2:0], 1'b0} >= sum[k-1]) begin
            rem[k][l] <= {rem[k-1][l][SUM_W-2:0], 1'b0} - sum[k-1];
            quo[k][l] <= {quo[k-1][l][QW-2:0], 1'b1};
          end else begin
            rem[k][l] <= {rem[k-1][l][SUM_W-2:0], 1'b0};
            quo[k][l] <= {quo[k-1][l][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign out_valid = valid[QW-1];
  assign out_q     = quo[QW-1];
  assign out_side  = side[QW-1];

endmodule
